[rtl/core/dmac_pkg.sv]
// ----------------------------------------------------------------------------
// dmac_pkg
// Shared types and codes for the DMA controller register block.
// ----------------------------------------------------------------------------
package dmac_pkg;

    localparam int NUM_CHAN = 4;
    localparam int CHAN_W   = 2;
    localparam int ADDR_W   = 24;
    localparam int COUNT_W  = 16;
    localparam int MEM_W    = 25;
    localparam int LEN_W    = 17;

    // request opcodes
    localparam logic [1:0] OP_PORT_WRITE = 2'd0;
    localparam logic [1:0] OP_PORT_READ  = 2'd1;
    localparam logic [1:0] OP_PERIPH     = 2'd2;
    localparam logic [1:0] OP_COMPLETE   = 2'd3;

    // I/O ports
    localparam logic [7:0] PORT_CH2_ADDR  = 8'h04;
    localparam logic [7:0] PORT_CH2_COUNT = 8'h05;
    localparam logic [7:0] PORT_STATUS    = 8'h08;
    localparam logic [7:0] PORT_MASK      = 8'h0A;
    localparam logic [7:0] PORT_MODE      = 8'h0B;
    localparam logic [7:0] PORT_CLR_PTR   = 8'h0C;
    localparam logic [7:0] PORT_MCLEAR    = 8'h0D;
    localparam logic [7:0] PORT_CH2_PAGE  = 8'h81;

    // mode byte fields
    localparam logic [1:0] XFER_VERIFY = 2'b00;
    localparam logic [1:0] XFER_WRITE  = 2'b01;
    localparam int         MODE_XFER_LO   = 2;
    localparam int         MODE_AUTOINIT  = 4;
    localparam int         MODE_REVERSE   = 5;
    localparam int         MASK_SET_BIT   = 2;

    localparam logic [3:0] MASK_RESET = 4'hF;
    localparam logic [7:0] STATUS_KEEP = 8'hF0;

    // reject reasons
    localparam logic [2:0] RSN_OK        = 3'd0;
    localparam logic [2:0] RSN_MASKED    = 3'd1;
    localparam logic [2:0] RSN_XFER_TYPE = 3'd2;
    localparam logic [2:0] RSN_MODE      = 3'd3;
    localparam logic [2:0] RSN_BOUNDS    = 3'd4;

    typedef struct packed {
        logic [7:0]         read_data;
        logic               accepted;
        logic [2:0]         reject_reason;
        logic               mem_write;
        logic [MEM_W-1:0]   mem_address;
        logic [7:0]         mem_data;
        logic [LEN_W-1:0]   transfer_length;
    } result_t;

endpackage

[rtl/core/dmac_core.sv]
// ----------------------------------------------------------------------------
// dmac_core
// Channel register file, port decode and peripheral byte checks.
// ----------------------------------------------------------------------------
module dmac_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [1:0]                  opcode,
    input  logic [7:0]                  port,
    input  logic [7:0]                  wdata,
    input  logic [dmac_pkg::CHAN_W-1:0] chan,
    input  logic [15:0]                 byte_offset,
    input  logic [7:0]                  data_byte,
    output dmac_pkg::result_t           result
);

    logic [7:0]                      chan_mode_reg    [dmac_pkg::NUM_CHAN];
    logic [dmac_pkg::ADDR_W-1:0]     chan_address_reg [dmac_pkg::NUM_CHAN];
    logic [dmac_pkg::COUNT_W-1:0]    chan_count_reg   [dmac_pkg::NUM_CHAN];
    logic [7:0]                      chan_mode_next    [dmac_pkg::NUM_CHAN];
    logic [dmac_pkg::ADDR_W-1:0]     chan_address_next [dmac_pkg::NUM_CHAN];
    logic [dmac_pkg::COUNT_W-1:0]    chan_count_next   [dmac_pkg::NUM_CHAN];
    logic [3:0]                      mask_bits_reg,    mask_bits_next;
    logic [7:0]                      status_bits_reg,  status_bits_next;
    logic                            byte_pointer_reg, byte_pointer_next;

    logic [dmac_pkg::CHAN_W-1:0]     wsel;
    logic [7:0]                      sel_mode;
    logic [1:0]                      sel_xfer;
    logic [2:0]                      reason;

    assign wsel = wdata[dmac_pkg::CHAN_W-1:0];

    // state update for one request
    always_comb
    begin
        chan_mode_next    = chan_mode_reg;
        chan_address_next = chan_address_reg;
        chan_count_next   = chan_count_reg;
        mask_bits_next    = mask_bits_reg;
        status_bits_next  = status_bits_reg;
        byte_pointer_next = byte_pointer_reg;
        case (opcode)
            dmac_pkg::OP_PORT_WRITE:
            begin
                case (port)
                    dmac_pkg::PORT_MCLEAR:
                    begin
                        for (int c = 0; c < dmac_pkg::NUM_CHAN; c++)
                        begin
                            chan_mode_next[c]    = '0;
                            chan_address_next[c] = '0;
                            chan_count_next[c]   = '0;
                        end
                        mask_bits_next    = dmac_pkg::MASK_RESET;
                        status_bits_next  = '0;
                        byte_pointer_next = 1'b0;
                    end
                    dmac_pkg::PORT_CLR_PTR:
                    begin
                        byte_pointer_next = 1'b0;
                    end
                    dmac_pkg::PORT_CH2_ADDR:
                    begin
                        if (byte_pointer_reg)
                            chan_address_next[2][15:8] = wdata;
                        else
                            chan_address_next[2][7:0] = wdata;
                        byte_pointer_next = ~byte_pointer_reg;
                    end
                    dmac_pkg::PORT_CH2_COUNT:
                    begin
                        if (byte_pointer_reg)
                            chan_count_next[2][15:8] = wdata;
                        else
                            chan_count_next[2][7:0] = wdata;
                        byte_pointer_next = ~byte_pointer_reg;
                    end
                    dmac_pkg::PORT_CH2_PAGE:
                    begin
                        chan_address_next[2][23:16] = wdata;
                    end
                    dmac_pkg::PORT_MODE:
                    begin
                        chan_mode_next[wsel] = wdata;
                    end
                    dmac_pkg::PORT_MASK:
                    begin
                        mask_bits_next[wsel]       = wdata[dmac_pkg::MASK_SET_BIT];
                        status_bits_next[4 + wsel] = wdata[dmac_pkg::MASK_SET_BIT];
                    end
                    default:
                    begin
                    end
                endcase
            end
            dmac_pkg::OP_PORT_READ:
            begin
                // status read clears the completion bits
                if (port == dmac_pkg::PORT_STATUS)
                    status_bits_next = status_bits_reg & dmac_pkg::STATUS_KEEP;
            end
            dmac_pkg::OP_COMPLETE:
            begin
                status_bits_next[chan] = 1'b1;
                mask_bits_next[chan]   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign sel_mode = chan_mode_reg[chan];
    assign sel_xfer = sel_mode[dmac_pkg::MODE_XFER_LO +: 2];

    always_comb
    begin
        if (mask_bits_reg[chan])
            reason = dmac_pkg::RSN_MASKED;
        else if (sel_xfer != dmac_pkg::XFER_WRITE && sel_xfer != dmac_pkg::XFER_VERIFY)
            reason = dmac_pkg::RSN_XFER_TYPE;
        else if (sel_mode[dmac_pkg::MODE_AUTOINIT] || sel_mode[dmac_pkg::MODE_REVERSE])
            reason = dmac_pkg::RSN_MODE;
        else if (byte_offset > chan_count_reg[chan])
            reason = dmac_pkg::RSN_BOUNDS;
        else
            reason = dmac_pkg::RSN_OK;
    end

    always_comb
    begin
        result = '0;
        if (opcode == dmac_pkg::OP_PORT_READ && port == dmac_pkg::PORT_STATUS)
            result.read_data = status_bits_reg;
        if (opcode == dmac_pkg::OP_PERIPH)
        begin
            result.reject_reason = reason;
            if (reason == dmac_pkg::RSN_OK)
            begin
                result.accepted = 1'b1;
                if (sel_xfer == dmac_pkg::XFER_WRITE)
                begin
                    result.mem_write   = 1'b1;
                    result.mem_address = {1'b0, chan_address_reg[chan]}
                                       + {{(dmac_pkg::MEM_W-16){1'b0}}, byte_offset};
                    result.mem_data    = data_byte;
                end
            end
        end
        // length reflects the count after this request's update
        result.transfer_length = {1'b0, chan_count_next[chan]}
                               + {{(dmac_pkg::LEN_W-1){1'b0}}, 1'b1};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < dmac_pkg::NUM_CHAN; c++)
            begin
                chan_mode_reg[c]    <= '0;
                chan_address_reg[c] <= '0;
                chan_count_reg[c]   <= '0;
            end
            mask_bits_reg    <= dmac_pkg::MASK_RESET;
            status_bits_reg  <= '0;
            byte_pointer_reg <= 1'b0;
        end
        else if (take)
        begin
            chan_mode_reg    <= chan_mode_next;
            chan_address_reg <= chan_address_next;
            chan_count_reg   <= chan_count_next;
            mask_bits_reg    <= mask_bits_next;
            status_bits_reg  <= status_bits_next;
            byte_pointer_reg <= byte_pointer_next;
        end
    end

endmodule

[rtl/core/dmac_out_buf.sv]
// ----------------------------------------------------------------------------
// dmac_out_buf
// Result register with a skid entry that takes one more request under stall.
// ----------------------------------------------------------------------------
module dmac_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dmac_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output dmac_pkg::result_t out_data
);

    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    dmac_pkg::result_t main_reg, main_next;
    dmac_pkg::result_t skid_reg, skid_next;
    logic              pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop && skid_valid_reg)
        begin
            // drain the skid entry into the output
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        else if (push && (!main_valid_reg || pop))
        begin
            main_next       = push_data;
            main_valid_next = 1'b1;
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

[rtl/core/dma_controller_registers.sv]
// ----------------------------------------------------------------------------
// dma_controller_registers
// Four-channel DMA register block, one request in and one result out.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (in_valid / in_stall) with an opcode:
// port write, port read, peripheral byte or transfer complete. Each request
// gives exactly one result on the output channel (out_valid / out_stall):
// status read data, accept/reject of a peripheral byte with the memory
// write it causes, and the selected channel's transfer length.
// A taken request's result is registered in the output or skid entry.
// Throughput is one request per cycle while the output is not stalled,
// set by the single decode and update pass over the channel registers.
// A stalled result holds at the output; a skid entry takes one more
// request behind it, then in_stall rises until the output drains.
// Reset (rst_n low) masks all channels, clears modes, addresses, counts,
// status and the byte pointer, and empties the result buffer. A master
// clear port write has the same effect on the channel registers.
// ----------------------------------------------------------------------------
module dma_controller_registers
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  port,
    input  logic [7:0]  wdata,
    input  logic [1:0]  chan,
    input  logic [15:0] byte_offset,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        accepted,
    output logic [2:0]  reject_reason,
    output logic        mem_write,
    output logic [24:0] mem_address,
    output logic [7:0]  mem_data,
    output logic [16:0] transfer_length
);

    logic              take;
    logic              full;
    dmac_pkg::result_t core_result;
    dmac_pkg::result_t out_data;

    assign in_stall = full;
    assign take     = in_valid && !full;

    dmac_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .opcode      (opcode),
        .port        (port),
        .wdata       (wdata),
        .chan        (chan),
        .byte_offset (byte_offset),
        .data_byte   (data_byte),
        .result      (core_result)
    );

    dmac_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (core_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign read_data       = out_data.read_data;
    assign accepted        = out_data.accepted;
    assign reject_reason   = out_data.reject_reason;
    assign mem_write       = out_data.mem_write;
    assign mem_address     = out_data.mem_address;
    assign mem_data        = out_data.mem_data;
    assign transfer_length = out_data.transfer_length;

endmodule

[rtl/core/dmac_checker.sv]
// ----------------------------------------------------------------------------
// dmac_checker
// Port-level checks on the DMA register block results.
// ----------------------------------------------------------------------------
module dmac_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  read_data,
    input  logic        accepted,
    input  logic [2:0]  reject_reason,
    input  logic        mem_write,
    input  logic [16:0] transfer_length
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data)
            && $stable(mem_write) && $stable(transfer_length))
        else $error("stalled result changed");

    a_accept_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> reject_reason == dmac_pkg::RSN_OK)
        else $error("accepted byte carries a reject reason");

    a_write_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mem_write |-> accepted)
        else $error("memory write on a rejected byte");

    // status data only on reads, never together with byte fields
    a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_data != 8'd0 |-> !accepted
            && reject_reason == dmac_pkg::RSN_OK && transfer_length != 17'd0)
        else $error("read data mixed with byte result");

endmodule

bind dma_controller_registers dmac_checker u_dmac_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .read_data       (read_data),
    .accepted        (accepted),
    .reject_reason   (reject_reason),
    .mem_write       (mem_write),
    .transfer_length (transfer_length)
);

[dv/dma_reg_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_reg_scoreboard_pkg
// Predicts and checks the results of the DMA controller register block.
// The class keeps its own copy of the channel registers, works out the one
// result each accepted request causes, and compares results in order.
// ----------------------------------------------------------------------------
package dma_reg_scoreboard_pkg;

    import dmac_pkg::*;

    class dma_reg_scoreboard;

        logic [7:0]         mode_reg    [NUM_CHAN];
        logic [ADDR_W-1:0]  base_addr   [NUM_CHAN];
        logic [COUNT_W-1:0] xfer_count  [NUM_CHAN];
        logic [3:0]         chan_masked;
        logic [7:0]         status_reg;
        logic               hi_byte_next;

        result_t pending_results [$];

        int errors;
        int n_checked;
        int n_requests;
        int n_status_reads;
        int n_accepted;
        int n_mem_writes;
        int n_rejected;

        function new();
            clear_regs();
            errors         = 0;
            n_checked      = 0;
            n_requests     = 0;
            n_status_reads = 0;
            n_accepted     = 0;
            n_mem_writes   = 0;
            n_rejected     = 0;
        endfunction

        function void clear_regs();
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                mode_reg[c]   = '0;
                base_addr[c]  = '0;
                xfer_count[c] = '0;
            end
            chan_masked  = MASK_RESET;
            status_reg   = '0;
            hi_byte_next = 1'b0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Update the register copy for one accepted request and queue its result.
        function void note_request(logic [1:0] op, logic [7:0] prt, logic [7:0] wd,
                                   logic [1:0] ch, logic [15:0] off, logic [7:0] db);
            result_t    r;
            logic [7:0] m;
            logic [1:0] xf;
            logic [1:0] sel;
            logic [2:0] rsn;
            r   = '0;
            sel = wd[1:0];
            n_requests++;
            case (op)
                OP_PORT_WRITE:
                begin
                    case (prt)
                        PORT_MCLEAR:  clear_regs();
                        PORT_CLR_PTR: hi_byte_next = 1'b0;
                        PORT_CH2_ADDR:
                        begin
                            if (hi_byte_next)
                                base_addr[2][15:8] = wd;
                            else
                                base_addr[2][7:0] = wd;
                            hi_byte_next = ~hi_byte_next;
                        end
                        PORT_CH2_COUNT:
                        begin
                            if (hi_byte_next)
                                xfer_count[2][15:8] = wd;
                            else
                                xfer_count[2][7:0] = wd;
                            hi_byte_next = ~hi_byte_next;
                        end
                        PORT_CH2_PAGE: base_addr[2][23:16] = wd;
                        PORT_MODE:     mode_reg[sel] = wd;
                        PORT_MASK:
                        begin
                            chan_masked[sel]    = wd[MASK_SET_BIT];
                            status_reg[4 + sel] = wd[MASK_SET_BIT];
                        end
                        default: ;
                    endcase
                end
                OP_PORT_READ:
                begin
                    if (prt == PORT_STATUS)
                    begin
                        n_status_reads++;
                        r.read_data = status_reg;
                        status_reg  = status_reg & STATUS_KEEP;
                    end
                end
                OP_PERIPH:
                begin
                    m  = mode_reg[ch];
                    xf = m[MODE_XFER_LO +: 2];
                    if (chan_masked[ch])
                        rsn = RSN_MASKED;
                    else if (xf != XFER_WRITE && xf != XFER_VERIFY)
                        rsn = RSN_XFER_TYPE;
                    else if (m[MODE_AUTOINIT] || m[MODE_REVERSE])
                        rsn = RSN_MODE;
                    else if (off > xfer_count[ch])
                        rsn = RSN_BOUNDS;
                    else
                        rsn = RSN_OK;
                    r.reject_reason = rsn;
                    if (rsn == RSN_OK)
                    begin
                        n_accepted++;
                        r.accepted = 1'b1;
                        if (xf == XFER_WRITE)
                        begin
                            n_mem_writes++;
                            r.mem_write   = 1'b1;
                            r.mem_address = {1'b0, base_addr[ch]} + MEM_W'(off);
                            r.mem_data    = db;
                        end
                    end
                    else
                        n_rejected++;
                end
                default:
                begin
                    status_reg[ch]  = 1'b1;
                    chan_masked[ch] = 1'b1;
                end
            endcase
            // length reflects the registers after this request
            r.transfer_length = {1'b0, xfer_count[ch]} + LEN_W'(1);
            pending_results.push_back(r);
        endfunction

        function void cmp_field(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(result_t act);
            result_t exp_r;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request waiting: expected none, actual %0h",
                         $time, act);
                return;
            end
            exp_r = pending_results.pop_front();
            n_checked++;
            cmp_field("read_data",       exp_r.read_data,       act.read_data);
            cmp_field("accepted",        exp_r.accepted,        act.accepted);
            cmp_field("reject_reason",   exp_r.reject_reason,   act.reject_reason);
            cmp_field("mem_write",       exp_r.mem_write,       act.mem_write);
            cmp_field("mem_address",     exp_r.mem_address,     act.mem_address);
            cmp_field("mem_data",        exp_r.mem_data,        act.mem_data);
            cmp_field("transfer_length", exp_r.transfer_length, act.transfer_length);
        endfunction

    endclass

endpackage

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the DMA controller register block.
// Drives directed and random port writes, port reads, peripheral bytes and
// transfer completions with random gaps and output stalls, including one
// long output hold, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    import dmac_pkg::*;
    import dma_reg_scoreboard_pkg::*;

    localparam int N_RANDOM    = 1750;
    localparam int CYCLE_LIMIT = 250000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [7:0]  port;
    logic [7:0]  wdata;
    logic [1:0]  chan;
    logic [15:0] byte_offset;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_data;
    logic        accepted;
    logic [2:0]  reject_reason;
    logic        mem_write;
    logic [24:0] mem_address;
    logic [7:0]  mem_data;
    logic [16:0] transfer_length;

    dma_reg_scoreboard sb;
    bit no_idle;
    int pressure_hold;

    dma_controller_registers dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .port            (port),
        .wdata           (wdata),
        .chan            (chan),
        .byte_offset     (byte_offset),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .accepted        (accepted),
        .reject_reason   (reject_reason),
        .mem_write       (mem_write),
        .mem_address     (mem_address),
        .mem_data        (mem_data),
        .transfer_length (transfer_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_draw();
        if (no_idle)
            return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 2);
            2:       return $urandom_range(0, 16);
            default: return $urandom_range(0, 1);
        endcase
    endfunction

    // Offer one request after a random gap and hold it until taken.
    task automatic send_request(input logic [1:0] op, input logic [7:0] prt,
                                input logic [7:0] wd, input logic [1:0] ch,
                                input logic [15:0] off, input logic [7:0] db);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode      = op;
        port        = prt;
        wdata       = wd;
        chan        = ch;
        byte_offset = off;
        data_byte   = db;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(op, prt, wd, ch, off, db);
        @(negedge clk);
    endtask

    initial
    begin : result_sink
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_result({read_data, accepted, reject_reason, mem_write,
                                 mem_address, mem_data, transfer_length});
                hold = idle_draw();
            end
            if (pressure_hold > 0)
            begin
                hold          = pressure_hold;
                pressure_hold = 0;
            end
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall = 1'b1;
                hold--;
            end
            else
                out_stall = 1'b0;
        end
    end

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int          sel;
        int          sub;
        int          lim;
        logic [1:0]  op;
        logic [1:0]  ch;
        logic [7:0]  prt;
        logic [7:0]  wd;
        logic [7:0]  db;
        logic [15:0] off;

        sb            = new();
        no_idle       = 1'b0;
        pressure_hold = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_PORT_WRITE;
        port          = '0;
        wdata         = '0;
        chan          = '0;
        byte_offset   = '0;
        data_byte     = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset state, channel 2 programming, each reject path
        send_request(OP_PORT_READ,  PORT_STATUS, 8'h00, 2'd0, 16'h0000, 8'h00);
        send_request(OP_PERIPH,     8'h00, 8'h00, 2'd2, 16'h0000, 8'h5A);
        send_request(OP_PORT_WRITE, PORT_MASK, 8'h02, 2'd0, 16'h0000, 8'h00);
        send_request(OP_PERIPH,     8'h00, 8'h00, 2'd2, 16'h0000, 8'hA5);
        send_request(OP_PERIPH,     8'h00, 8'h00, 2'd2, 16'h0001, 8'hA5);
        send_request(OP_PORT_WRITE, PORT_CLR_PTR, 8'h00, 2'd0, 16'h0000, 8'h00);
        send_request(OP_PORT_WRITE, PORT_CH2_ADDR, 8'hFF, 2'd0, 16'h0000, 8'h00);
        send_request(OP_PORT_WRITE, PORT_CH2_ADDR, 8'hFF, 2'd0, 16'h0000, 8'h00);
        send_request(OP_PORT_WRITE, PORT_CH2_PAGE, 8'hFF, 2'd0, 16'h0000, 8'h00);
        send_request(OP_PORT_WRITE, PORT_CH2_COUNT, 8'hFF, 2'd2, 16'h0000, 8'h00);
        send_request(OP_PORT_WRITE, PORT_CH2_COUNT, 8'hFF, 2'd2, 16'h0000, 8'h00);
        send_request(OP_PORT_WRITE, PORT_MODE, {4'b0000, XFER_WRITE, 2'd2}, 2'd2,
                     16'h0000, 8'h00);
        send_request(OP_PERIPH,     8'h00, 8'h00, 2'd2, 16'hFFFF, 8'hFF);
        send_request(OP_PERIPH,     8'h00, 8'h00, 2'd2, 16'h0000, 8'h00);
        send_request(OP_PORT_WRITE, PORT_MODE, {4'b0000, 2'b10, 2'd2}, 2'd2,
                     16'h0000, 8'h00);
        send_request(OP_PERIPH,     8'h00, 8'h00, 2'd2, 16'h0010, 8'h11);
        send_request(OP_PORT_WRITE, PORT_MODE, {4'b0001, XFER_WRITE, 2'd2}, 2'd2,
                     16'h0000, 8'h00);
        send_request(OP_PERIPH,     8'h00, 8'h00, 2'd2, 16'h0010, 8'h22);
        send_request(OP_PORT_WRITE, PORT_MODE, {4'b0010, XFER_VERIFY, 2'd2}, 2'd2,
                     16'h0000, 8'h00);
        send_request(OP_PERIPH,     8'h00, 8'h00, 2'd2, 16'h0010, 8'h33);
        send_request(OP_COMPLETE,   8'h00, 8'h00, 2'd2, 16'h0000, 8'h00);
        send_request(OP_PORT_READ,  PORT_STATUS, 8'h00, 2'd2, 16'h0000, 8'h00);
        send_request(OP_PORT_READ,  PORT_STATUS, 8'h00, 2'd3, 16'h0000, 8'h00);
        send_request(OP_PORT_WRITE, PORT_MASK, 8'hFF, 2'd1, 16'h0000, 8'h00);
        send_request(OP_PORT_READ,  8'h09, 8'h00, 2'd1, 16'h0000, 8'h00);
        send_request(OP_PORT_WRITE, 8'h00, 8'hFF, 2'd3, 16'h0000, 8'h00);
        send_request(OP_PORT_WRITE, PORT_MCLEAR, 8'h00, 2'd2, 16'h0000, 8'h00);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            no_idle = ((i / 150) % 4 == 2);
            // long output hold while the sender keeps offering requests
            if (i == 900)
                pressure_hold = 300;
            op  = 2'($urandom);
            prt = 8'($urandom);
            wd  = 8'($urandom);
            ch  = 2'($urandom);
            off = 16'($urandom);
            db  = 8'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                op = OP_PERIPH;
                if ($urandom_range(0, 1))
                    ch = 2'd2;
                sub = $urandom_range(0, 9);
                if (sub < 6)
                    off = 16'($urandom_range(0, sb.xfer_count[ch]));
                else if (sub < 8)
                begin
                    lim = sb.xfer_count[ch] + 1 + $urandom_range(0, 3);
                    off = (lim > 65535) ? 16'hFFFF : 16'(lim);
                end
            end
            else if (sel < 40)
            begin
                op = OP_PORT_WRITE;
                prt = PORT_MASK;
                wd[MASK_SET_BIT] = ($urandom_range(0, 9) < 3);
            end
            else if (sel < 50)
            begin
                op = OP_PORT_WRITE;
                prt = PORT_MODE;
                // mostly usable modes, now and then a raw mode byte
                if ($urandom_range(0, 4) != 0)
                begin
                    wd[MODE_AUTOINIT] = 1'b0;
                    wd[MODE_REVERSE]  = 1'b0;
                    wd[MODE_XFER_LO +: 2] = ($urandom_range(0, 9) < 7) ? XFER_WRITE
                                                                       : XFER_VERIFY;
                end
            end
            else if (sel < 65)
            begin
                op = OP_PORT_WRITE;
                case ($urandom_range(0, 3))
                    0:       prt = PORT_CH2_ADDR;
                    1:       prt = PORT_CH2_COUNT;
                    2:       prt = PORT_CH2_PAGE;
                    default: prt = PORT_CLR_PTR;
                endcase
            end
            else if (sel < 75)
            begin
                op = OP_PORT_READ;
                if ($urandom_range(0, 4) != 0)
                    prt = PORT_STATUS;
            end
            else if (sel < 82)
                op = OP_COMPLETE;
            else if (sel == 82)
            begin
                op = OP_PORT_WRITE;
                prt = PORT_MCLEAR;
            end
            send_request(op, prt, wd, ch, off, db);
        end
        in_valid = 1'b0;
        no_idle  = 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Covered %0d requests: %0d status reads, %0d bytes taken (%0d memory writes),",
                 sb.n_requests, sb.n_status_reads, sb.n_accepted, sb.n_mem_writes);
        $display("%0d bytes rejected; %0d results checked, %0d mismatches.",
                 sb.n_rejected, sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
